// ===== rtl/image_convolution_2d_macros.svh =====
// Assertion macros shared by the convolution block.
`ifndef IMAGE_CONVOLUTION_2D_MACROS_SVH
`define IMAGE_CONVOLUTION_2D_MACROS_SVH

`ifndef ASSERT_OFF
// Checks a property on every rising clock edge outside reset.
`define ICV_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("convolution assertion failed");
// Checks that a condition never holds outside reset.
`define ICV_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("convolution assertion failed");
`else
`define ICV_ASSERT(lbl, clk, rst_n, prop)
`define ICV_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== rtl/icv_pkg.sv =====
// Shared types, codes and default sizes of the 2-D convolution block.
`timescale 1ns / 1ps

package icv_pkg;

	// Default maximum frame and kernel sizes.
	localparam int DEF_MAX_WIDTH    = 128;
	localparam int DEF_MAX_HEIGHT   = 128;
	localparam int DEF_MAX_CHANNELS = 4;
	localparam int DEF_MAX_RADIUS   = 3;

	// Requested register values after reset, before saturation.
	localparam int RST_WIDTH    = 128;
	localparam int RST_HEIGHT   = 128;
	localparam int RST_CHANNELS = 1;
	localparam int RST_RADIUS   = 1;

	// Field widths.
	localparam int PIX_W  = 8;
	localparam int COEF_W = 16;
	localparam int OFF_W  = 4;

	// Item function codes.
	localparam logic [1:0] FUNC_COEF    = 2'd0;
	localparam logic [1:0] FUNC_PIXEL   = 2'd1;
	localparam logic [1:0] FUNC_COMPUTE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_CHANNELS = 2'd2;
	localparam logic [1:0] REG_RADIUS   = 2'd3;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [PIX_W-1:0] pix_t;

	// Control of the multiply-accumulate unit.
	typedef struct packed {
		logic clr;
		logic tap_vld;
	} mac_ctrl_t;

endpackage

// ===== rtl/icv_coef_ram.sv =====
// Kernel coefficient memory with per-entry valid bits that reset clears.
`timescale 1ns / 1ps

module icv_coef_ram #(
	parameter int DEPTH = 49
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  icv_pkg::coef_t                  wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output icv_pkg::coef_t                  rd_data
);

	icv_pkg::coef_t mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	icv_pkg::coef_t rd_data_q;

	// Valid bits: an entry reads as zero until it is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Storage write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data_q <= vld_q[rd_addr] ? mem[rd_addr] : '0;
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/icv_frame_ram.sv =====
// Single-port frame sample memory with registered read data.
`timescale 1ns / 1ps

module icv_frame_ram #(
	parameter int DEPTH = 65536
) (
	input  logic                                         clk,
	input  logic                                         en,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  icv_pkg::pix_t                                wr_data,
	output icv_pkg::pix_t                                rd_data
);

	icv_pkg::pix_t mem [DEPTH];
	icv_pkg::pix_t rd_data_q;

	// One access per cycle: either a write or a registered read.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wr_data;
			end else begin
				rd_data_q <= mem[addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/icv_mac.sv =====
// Shared multiply-accumulate unit with the final shift and clamp to a byte.
`timescale 1ns / 1ps

module icv_mac #(
	parameter int TAPS = 49
) (
	input  logic              clk,
	input  logic              arst_n,
	input  icv_pkg::mac_ctrl_t ctrl,
	input  icv_pkg::coef_t    coef,
	input  icv_pkg::pix_t     pix,
	output icv_pkg::pix_t     sat_byte
);

	localparam int PROD_W = icv_pkg::COEF_W + icv_pkg::PIX_W + 1;
	localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;

	logic signed [PROD_W-1:0] prod_s4;
	logic                     vld_s4;
	logic signed [ACC_W-1:0]  acc_q;

	// Product stage.
	always_ff @(posedge clk) begin
		prod_s4 <= coef * $signed({1'b0, pix});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= ctrl.tap_vld;
		end
	end

	// Accumulator, cleared when a new window starts.
	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (vld_s4) begin
			acc_q <= acc_q + ACC_W'(prod_s4);
		end
	end

	// Drop the eight fraction bits and clamp to 0..255.
	always_comb begin
		if (acc_q[ACC_W-1]) begin
			sat_byte = '0;
		end else if (acc_q[ACC_W-2:16] != '0) begin
			sat_byte = 8'd255;
		end else begin
			sat_byte = acc_q[15:8];
		end
	end

endmodule

// ===== rtl/image_convolution_2d.sv =====
// Top level of the zero-padded 2-D convolution block: sequencer and address pipeline.
`timescale 1ns / 1ps
`include "image_convolution_2d_macros.svh"

// Usage: an item is taken at a rising edge with start high and busy low. func selects a
// coefficient write, a pixel sample write or a compute request for one output sample.
// A coefficient write completes at the accepting edge and leaves busy low.
// A pixel write inside the frame holds busy while its address is formed.
// A compute request inside the frame walks the (2r+1)^2 window one tap per cycle through
// the shared multiply-accumulate unit, then drains its 4-stage pipeline; done and the
// result are registered in the reporting state that follows the drain.
// A compute request outside the frame skips the walk and answers with out_of_range set.
// Items do not overlap: a new item is taken only once busy has fallen after the last one.
// The result is shown for exactly one cycle with done high; the receiver cannot stall.
// Configuration writes use cfg_valid/cfg_ready, always ready; the user must make them
// while idle, as the block does not enforce it. Reset clears the sequencer, restores the
// register defaults and zeroes the kernel. Frame samples are undefined until written.
module image_convolution_2d #(
	parameter int MAX_WIDTH    = icv_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = icv_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = icv_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_RADIUS   = icv_pkg::DEF_MAX_RADIUS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          func,
	input  logic [6:0]          x_pos,
	input  logic [6:0]          y_pos,
	input  logic [1:0]          chan,
	input  logic [7:0]          pixel_value,
	input  logic [5:0]          coef_index,
	input  logic signed [15:0]  coef_value,
	output logic                done,
	output logic [7:0]          result_pixel,
	output logic                out_of_range,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	localparam int KSIDE = 2 * MAX_RADIUS + 1;
	localparam int KTAPS = KSIDE * KSIDE;
	localparam int KW    = (KTAPS > 1) ? $clog2(KTAPS) : 1;
	localparam int FRAME_BYTES = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
	localparam int FAW   = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam int OW    = icv_pkg::OFF_W;

	localparam logic [7:0] WIDTH_RST = 8'((MAX_WIDTH < icv_pkg::RST_WIDTH) ?
		MAX_WIDTH : icv_pkg::RST_WIDTH);
	localparam logic [7:0] HEIGHT_RST = 8'((MAX_HEIGHT < icv_pkg::RST_HEIGHT) ?
		MAX_HEIGHT : icv_pkg::RST_HEIGHT);
	localparam logic [2:0] CHAN_RST = 3'((MAX_CHANNELS < icv_pkg::RST_CHANNELS) ?
		MAX_CHANNELS : icv_pkg::RST_CHANNELS);
	localparam logic [1:0] RADIUS_RST = 2'((MAX_RADIUS < icv_pkg::RST_RADIUS) ?
		MAX_RADIUS : icv_pkg::RST_RADIUS);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_WALK   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_RESULT = 2'd3;

	localparam logic [1:0] DRAIN_LAST = 2'd3;

	// Configuration registers.
	logic [7:0] width_q;
	logic [7:0] height_q;
	logic [2:0] chans_q;
	logic [1:0] radius_q;

	// Sequencer state.
	logic [1:0]           state_q;
	logic [1:0]           drain_q;
	logic signed [OW-1:0] i_q;
	logic signed [OW-1:0] j_q;
	logic [KW-1:0]        k_q;
	logic                 wr_q;
	logic                 done_q;

	// Latched item fields.
	logic [6:0]    x_q;
	logic [6:0]    y_q;
	logic [1:0]    c_q;
	icv_pkg::pix_t pv_q;
	logic          oor_q;
	icv_pkg::pix_t result_q;
	logic          oor_res_q;

	// Address pipeline.
	logic          v_s1;
	logic          wr_s1;
	logic [KW-1:0] k_s1;
	logic [16:0]   t_s1;
	logic          v_s2;
	logic          wr_s2;
	logic [KW-1:0] k_s2;
	logic [19:0]   addr_s2;
	logic          rd_s3;

	logic                 accept;
	logic                 in_frame;
	logic signed [OW-1:0] r_s;
	logic                 last_tap;
	logic signed [9:0]    x2;
	logic signed [9:0]    y2;
	logic                 tap_ok;
	logic [15:0]          yw_c;
	logic [16:0]          t_c;
	logic [19:0]          tc_c;
	logic [19:0]          addr_c;

	icv_pkg::mac_ctrl_t mac_ctrl;
	icv_pkg::coef_t     coef_rd;
	icv_pkg::pix_t      pix_rd;
	icv_pkg::pix_t      mac_byte;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_frame  = ({1'b0, x_pos} < width_q) && ({1'b0, y_pos} < height_q) &&
		({1'b0, chan} < chans_q);
	assign r_s       = $signed({{(OW-2){1'b0}}, radius_q});
	assign last_tap  = wr_q || ((i_q == r_s) && (j_q == r_s));

	// Configuration writes, saturated; channels and radius take only the low cfg_data bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			chans_q  <= CHAN_RST;
			radius_q <= RADIUS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				icv_pkg::REG_WIDTH: begin
					if (cfg_data == '0) begin
						width_q <= 8'd1;
					end else if ({24'd0, cfg_data} > 32'(MAX_WIDTH)) begin
						width_q <= 8'(MAX_WIDTH);
					end else begin
						width_q <= cfg_data;
					end
				end
				icv_pkg::REG_HEIGHT: begin
					if (cfg_data == '0) begin
						height_q <= 8'd1;
					end else if ({24'd0, cfg_data} > 32'(MAX_HEIGHT)) begin
						height_q <= 8'(MAX_HEIGHT);
					end else begin
						height_q <= cfg_data;
					end
				end
				icv_pkg::REG_CHANNELS: begin
					if (cfg_data[2:0] == '0) begin
						chans_q <= 3'd1;
					end else if ({29'd0, cfg_data[2:0]} > 32'(MAX_CHANNELS)) begin
						chans_q <= 3'(MAX_CHANNELS);
					end else begin
						chans_q <= cfg_data[2:0];
					end
				end
				icv_pkg::REG_RADIUS: begin
					if ({30'd0, cfg_data[1:0]} > 32'(MAX_RADIUS)) begin
						radius_q <= 2'(MAX_RADIUS);
					end else begin
						radius_q <= cfg_data[1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Item fields are captured when the item is taken.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= x_pos;
			y_q   <= y_pos;
			c_q   <= chan;
			pv_q  <= pixel_value;
			oor_q <= !in_frame;
		end
	end

	// Sequencer: walks the window one tap per cycle, drains, then reports a compute result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			drain_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			wr_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (func == icv_pkg::FUNC_COMPUTE) begin
							wr_q <= 1'b0;
							i_q  <= -r_s;
							j_q  <= -r_s;
							k_q  <= '0;
							state_q <= in_frame ? ST_WALK : ST_RESULT;
						end else if (func == icv_pkg::FUNC_PIXEL && in_frame) begin
							wr_q <= 1'b1;
							i_q  <= '0;
							j_q  <= '0;
							k_q  <= '0;
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (last_tap) begin
						drain_q <= DRAIN_LAST;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
						if (j_q == r_s) begin
							j_q <= -r_s;
							i_q <= i_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					if (drain_q == '0) begin
						state_q <= wr_q ? ST_IDLE : ST_RESULT;
					end else begin
						drain_q <= drain_q - 1'b1;
					end
				end
				ST_RESULT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result registers, loaded in the reporting cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT) begin
			result_q  <= oor_q ? '0 : mac_byte;
			oor_res_q <= oor_q;
		end
	end

	// Neighbor coordinates and the zero-padding test.
	assign x2     = $signed({3'b000, x_q}) + 10'(i_q);
	assign y2     = $signed({3'b000, y_q}) + 10'(j_q);
	assign tap_ok = !x2[9] && !y2[9] && (x2 < $signed({2'b00, width_q})) &&
		(y2 < $signed({2'b00, height_q}));

	// Address stage one: row times width plus column.
	assign yw_c = y2[7:0] * width_q;
	assign t_c  = {1'b0, yw_c} + {9'd0, x2[7:0]};

	// Address stage two: pixel index times channels plus channel.
	assign tc_c   = t_s1 * chans_q;
	assign addr_c = tc_c + {18'd0, c_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			wr_s1 <= 1'b0;
			wr_s2 <= 1'b0;
			rd_s3 <= 1'b0;
		end else begin
			v_s1  <= (state_q == ST_WALK) && tap_ok;
			wr_s1 <= wr_q;
			v_s2  <= v_s1;
			wr_s2 <= wr_s1;
			rd_s3 <= v_s2 && !wr_s2;
		end
	end

	always_ff @(posedge clk) begin
		t_s1    <= t_c;
		k_s1    <= k_q;
		addr_s2 <= addr_c;
		k_s2    <= k_s1;
	end

	assign mac_ctrl.clr     = accept && (func == icv_pkg::FUNC_COMPUTE);
	assign mac_ctrl.tap_vld = rd_s3;

	icv_coef_ram #(
		.DEPTH(KTAPS)
	) u_coef_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && (func == icv_pkg::FUNC_COEF) &&
			({26'd0, coef_index} < 32'(KTAPS))),
		.wr_addr (KW'(coef_index)),
		.wr_data (coef_value),
		.rd_addr (k_s2),
		.rd_data (coef_rd)
	);

	icv_frame_ram #(
		.DEPTH(FRAME_BYTES)
	) u_frame_ram (
		.clk     (clk),
		.en      (v_s2),
		.we      (wr_s2),
		.addr    (FAW'(addr_s2)),
		.wr_data (pv_q),
		.rd_data (pix_rd)
	);

	icv_mac #(
		.TAPS(KTAPS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mac_ctrl),
		.coef     (coef_rd),
		.pix      (pix_rd),
		.sat_byte (mac_byte)
	);

	assign done         = done_q;
	assign result_pixel = result_q;
	assign out_of_range = oor_res_q;

	// The strobe is only raised once the sequencer has returned to idle.
	`ICV_ASSERT(a_done_idle, clk, arst_n, done |-> (state_q == ST_IDLE))
	// A request outside the frame always reports a zero byte.
	`ICV_ASSERT(a_oor_zero, clk, arst_n, (done && out_of_range) |-> (result_pixel == 8'd0))
	// A request outside the frame skips the window walk.
	`ICV_ASSERT(a_oor_fast, clk, arst_n,
		(accept && (func == icv_pkg::FUNC_COMPUTE) && !in_frame) |=> (state_q == ST_RESULT))
	// Taps only reach the accumulator while an item is in progress.
	`ICV_NEVER(a_tap_idle, clk, arst_n, mac_ctrl.tap_vld && !busy)
	// A pixel write never produces a result.
	`ICV_ASSERT(a_write_quiet, clk, arst_n, (accept && (func == icv_pkg::FUNC_PIXEL)) |=> !done)

endmodule
